>>> rtl/iirtdf2_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths, request and register codes, and datapath control
// types for the transposed direct form II IIR filter. No dependencies.
package iirtdf2_pkg;

   localparam int MAX_TAPS  = 16;
   localparam int TAP_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int DLY_DEPTH = MAX_TAPS - 1;
   localparam int DLY_AW    = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;

   localparam int COEF_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 5;
   localparam int FRAC_W   = 23;
   localparam int STATE_W  = 48;
   localparam int YH_W     = STATE_W - FRAC_W;
   localparam int MUL_B_W  = YH_W;
   localparam int PROD_W   = COEF_W + MUL_B_W;
   localparam int ACC_W    = PROD_W + 1;

   typedef enum logic [1:0] {
      OP_FILTER    = 2'd0,
      OP_WRITE_NUM = 2'd1,
      OP_WRITE_DEN = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_FEEDBACK  = 1'd0,
      CSR_TAP_COUNT = 1'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      MUL_BX,
      MUL_AYH,
      MUL_AYL
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SUB_HIGH,
      ACC_SUB_LOW
   } acc_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        load_y;
   } mac_ctrl_type;

endpackage

>>> rtl/iirtdf2_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iirtdf2_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/iirtdf2_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one multiplier, product register, accumulator,
// output register y and the final rounding. Depends on iirtdf2_pkg.
module iirtdf2_mac (
   input  logic                                    clock,
   input  iirtdf2_pkg::mac_ctrl_type               ctrl,
   input  logic signed [iirtdf2_pkg::COEF_W-1:0]   coef_b,
   input  logic signed [iirtdf2_pkg::COEF_W-1:0]   coef_a,
   input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [iirtdf2_pkg::STATE_W-1:0]  delay_in,
   output logic signed [iirtdf2_pkg::STATE_W-1:0]  delay_out,
   output logic signed [iirtdf2_pkg::SAMPLE_W-1:0] filtered,
   output logic                                    saturated
);

   localparam int PROD_W   = iirtdf2_pkg::PROD_W;
   localparam int ACC_W    = iirtdf2_pkg::ACC_W;
   localparam int STATE_W  = iirtdf2_pkg::STATE_W;
   localparam int FRAC_W   = iirtdf2_pkg::FRAC_W;
   localparam int MUL_B_W  = iirtdf2_pkg::MUL_B_W;
   localparam int SAMPLE_W = iirtdf2_pkg::SAMPLE_W;
   localparam int COEF_W   = iirtdf2_pkg::COEF_W;
   localparam int LOW_W    = PROD_W - FRAC_W;
   localparam int RND_W    = STATE_W + 1 - FRAC_W;

   localparam logic [PROD_W-1:0] PROD_HALF =
      {{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
   localparam logic [STATE_W:0] Y_HALF =
      {{(STATE_W+1-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
   localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'(32767);
   localparam logic signed [RND_W-1:0] OUT_MIN = -RND_W'(32768);

   // Clamp a wide sum to Q24.23.
   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [ACC_W-1:0] v
   );
      logic upper_or;
      logic upper_and;
      upper_or  = |v[ACC_W-2:STATE_W-1];
      upper_and = &v[ACC_W-2:STATE_W-1];
      if (!v[ACC_W-1] && upper_or) begin
         sat_state = {1'b0, {(STATE_W-1){1'b1}}};
      end else if (v[ACC_W-1] && !upper_and) begin
         sat_state = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         sat_state = v[STATE_W-1:0];
      end
   endfunction

   logic signed [COEF_W-1:0]  op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [STATE_W-1:0] y_in;
   logic signed [STATE_W-1:0] y_ff;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   sum_pd;
   logic signed [PROD_W-1:0]  low_sum;
   logic signed [ACC_W-1:0]   low_ext;
   logic        [STATE_W:0]   y_round;
   logic signed [RND_W-1:0]   rnd;

   always_comb begin
      op_a = coef_b;
      op_b = {{(MUL_B_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      case (ctrl.mul_sel)
         iirtdf2_pkg::MUL_BX: begin
            op_a = coef_b;
            op_b = {{(MUL_B_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
         end
         iirtdf2_pkg::MUL_AYH: begin
            op_a = coef_a;
            op_b = y_ff[STATE_W-1:FRAC_W];
         end
         iirtdf2_pkg::MUL_AYL: begin
            op_a = coef_a;
            op_b = {{(MUL_B_W-FRAC_W){1'b0}}, y_ff[FRAC_W-1:0]};
         end
         default: begin
            op_a = coef_b;
         end
      endcase
   end

   assign prod_in  = PROD_W'(op_a) * PROD_W'(op_b);
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign sum_pd   = prod_ext + {{(ACC_W-STATE_W){delay_in[STATE_W-1]}}, delay_in};

   // Round half up of the low partial product, scaled back by 2^-23.
   assign low_sum = prod_ff + PROD_HALF;
   assign low_ext = {{(ACC_W-LOW_W){low_sum[PROD_W-1]}}, low_sum[PROD_W-1:FRAC_W]};

   always_comb begin
      acc_in = acc_ff;
      case (ctrl.acc_op)
         iirtdf2_pkg::ACC_HOLD:     acc_in = acc_ff;
         iirtdf2_pkg::ACC_LOAD:     acc_in = sum_pd;
         iirtdf2_pkg::ACC_SUB_HIGH: acc_in = acc_ff - prod_ext;
         iirtdf2_pkg::ACC_SUB_LOW:  acc_in = acc_ff - low_ext;
         default:                   acc_in = acc_ff;
      endcase
      y_in = ctrl.load_y ? sat_state(sum_pd) : y_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      y_ff    <= y_in;
   end

   assign delay_out = sat_state(acc_ff);

   // Output: round y to an integer, then clip to 16 bits.
   assign y_round = {y_ff[STATE_W-1], y_ff} + Y_HALF;
   assign rnd     = y_round[STATE_W:FRAC_W];

   always_comb begin
      if (rnd > OUT_MAX) begin
         filtered  = OUT_MAX[SAMPLE_W-1:0];
         saturated = 1'b1;
      end else if (rnd < OUT_MIN) begin
         filtered  = OUT_MIN[SAMPLE_W-1:0];
         saturated = 1'b1;
      end else begin
         filtered  = rnd[SAMPLE_W-1:0];
         saturated = 1'b0;
      end
   end

endmodule

>>> rtl/iir_filter_transposed_df2.sv
`timescale 1ns / 1ps
// Top level of the transposed direct form II IIR filter: sequencer, coefficient
// and delay RAMs, settings. Depends on iirtdf2_pkg, iirtdf2_ram, iirtdf2_mac.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+-------------------
//   req     | in        | op, coef_index, coef_value, sample, first | valid / stall
//   rsp     | out       | filtered, saturated                     | valid / stall
//   csr     | in        | wr_en, index, wdata                     | write on wr_en
//
// Coefficient writes (op 1, op 2) and unused op 3 leave the sequencer idle, so the
// block stays ready. A filter request walks the n taps in use through the one shared
// multiplier: b*x, then, with feedback on, a*y split in a high and a low part.
// req_stall is high from acceptance of a filter request until its result sits in
// the output register. The result register holds while rsp_stall is high; the next
// request is accepted while it waits. Synchronous reset clears the delay line
// (valid bits) and the handshakes and sets feedback on and nine taps; coefficient
// RAMs need writing.
module iir_filter_transposed_df2 (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_op,
   input  logic [3:0]                              req_coef_index,
   input  logic signed [iirtdf2_pkg::COEF_W-1:0]   req_coef_value,
   input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                    req_first,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [iirtdf2_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                                    rsp_saturated,
   input  logic                                    csr_wr_en,
   input  logic [0:0]                              csr_index,
   input  logic [iirtdf2_pkg::COUNT_W-1:0]         csr_wdata
);

   localparam int MAX_TAPS  = iirtdf2_pkg::MAX_TAPS;
   localparam int TAP_W     = iirtdf2_pkg::TAP_W;
   localparam int DLY_DEPTH = iirtdf2_pkg::DLY_DEPTH;
   localparam int DLY_AW    = iirtdf2_pkg::DLY_AW;
   localparam int COEF_W    = iirtdf2_pkg::COEF_W;
   localparam int SAMPLE_W  = iirtdf2_pkg::SAMPLE_W;
   localparam int STATE_W   = iirtdf2_pkg::STATE_W;
   localparam int COUNT_W   = iirtdf2_pkg::COUNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_B,
      ST_ADD_B,
      ST_SUB_HIGH,
      ST_SUB_LOW,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // Settings
   logic               feedback_ff;
   logic [COUNT_W-1:0] tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         feedback_ff  <= 1'b1;
         tap_count_ff <= COUNT_W'(9);
      end else if (csr_wr_en) begin
         case (csr_index)
            iirtdf2_pkg::CSR_FEEDBACK:  feedback_ff  <= csr_wdata[0];
            iirtdf2_pkg::CSR_TAP_COUNT: tap_count_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Index of the last tap in use: a count of zero acts as one, and counts above
   // the store depth act as the full depth.
   logic [TAP_W-1:0] n_last;

   always_comb begin
      if (tap_count_ff == '0) begin
         n_last = '0;
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         n_last = TAP_W'(MAX_TAPS - 1);
      end else begin
         n_last = TAP_W'(tap_count_ff - COUNT_W'(1));
      end
   end

   // Sequencer state
   state_type                   state_ff, state_in;
   logic [TAP_W-1:0]            tap_ff, tap_in;
   logic [DLY_DEPTH-1:0]        dly_valid_ff, dly_valid_in;
   logic signed [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_filtered_ff, rsp_filtered_in;
   logic                        rsp_saturated_ff, rsp_saturated_in;

   logic                        req_accept;
   logic                        coef_idx_ok;
   logic                        num_wr_en;
   logic                        den_wr_en;
   logic                        dly_wr_en;
   logic [TAP_W-1:0]            coef_wr_addr;
   logic [TAP_W-1:0]            dly_wr_tap;
   logic [DLY_AW-1:0]           dly_wr_addr;
   logic                        use_delay;

   logic signed [COEF_W-1:0]    num_rd;
   logic signed [COEF_W-1:0]    den_rd;
   logic signed [STATE_W-1:0]   dly_rd;
   logic signed [STATE_W-1:0]   dly_sel;
   logic signed [STATE_W-1:0]   dly_wr_data;
   logic signed [SAMPLE_W-1:0]  mac_filtered;
   logic                        mac_saturated;
   iirtdf2_pkg::mac_ctrl_type   mac_ctrl;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign coef_idx_ok  = (int'(req_coef_index) < MAX_TAPS);
   assign coef_wr_addr = TAP_W'(req_coef_index);
   assign dly_wr_tap   = tap_ff - TAP_W'(1);
   assign dly_wr_addr  = dly_wr_tap[DLY_AW-1:0];

   // A delay entry feeds tap i only below the last tap, and only once written
   // since the last start of a block.
   assign use_delay = (tap_ff < n_last) && dly_valid_ff[tap_ff[DLY_AW-1:0]];
   assign dly_sel   = use_delay ? dly_rd : '0;

   always_comb begin
      state_in         = state_ff;
      tap_in           = tap_ff;
      dly_valid_in     = dly_valid_ff;
      sample_in        = sample_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_filtered_in  = rsp_filtered_ff;
      rsp_saturated_in = rsp_saturated_ff;
      num_wr_en        = 1'b0;
      den_wr_en        = 1'b0;
      dly_wr_en        = 1'b0;
      mac_ctrl.mul_sel = iirtdf2_pkg::MUL_BX;
      mac_ctrl.acc_op  = iirtdf2_pkg::ACC_HOLD;
      mac_ctrl.load_y  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (iirtdf2_pkg::op_type'(req_op))
                  iirtdf2_pkg::OP_FILTER: begin
                     sample_in = req_sample;
                     tap_in    = '0;
                     if (req_first) begin
                        dly_valid_in = '0;
                     end
                     state_in = ST_MUL_B;
                  end
                  iirtdf2_pkg::OP_WRITE_NUM: num_wr_en = coef_idx_ok;
                  iirtdf2_pkg::OP_WRITE_DEN: den_wr_en = coef_idx_ok;
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL_B: begin
            // b[i]*x into the product register
            mac_ctrl.mul_sel = iirtdf2_pkg::MUL_BX;
            state_in         = ST_ADD_B;
         end
         ST_ADD_B: begin
            // add the delay entry (into y at tap 0, else into the accumulator); start a[i]*y(high) for the feedback
            mac_ctrl.mul_sel = iirtdf2_pkg::MUL_AYH;
            if (tap_ff == '0) begin
               mac_ctrl.load_y = 1'b1;
               if (n_last == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  tap_in   = TAP_W'(1);
                  state_in = ST_MUL_B;
               end
            end else begin
               mac_ctrl.acc_op = iirtdf2_pkg::ACC_LOAD;
               state_in = feedback_ff ? ST_SUB_HIGH : ST_WRITE;
            end
         end
         ST_SUB_HIGH: begin
            mac_ctrl.mul_sel = iirtdf2_pkg::MUL_AYL;
            mac_ctrl.acc_op  = iirtdf2_pkg::ACC_SUB_HIGH;
            state_in         = ST_SUB_LOW;
         end
         ST_SUB_LOW: begin
            mac_ctrl.acc_op = iirtdf2_pkg::ACC_SUB_LOW;
            state_in        = ST_WRITE;
         end
         ST_WRITE: begin
            // store z[i-1], then advance to the next tap or finish
            dly_wr_en                 = 1'b1;
            dly_valid_in[dly_wr_addr] = 1'b1;
            if (tap_ff == n_last) begin
               state_in = ST_FINISH;
            end else begin
               tap_in   = tap_ff + TAP_W'(1);
               state_in = ST_MUL_B;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_filtered_in  = mac_filtered;
               rsp_saturated_in = mac_saturated;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         tap_ff           <= '0;
         dly_valid_ff     <= '0;
         sample_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         rsp_filtered_ff  <= '0;
         rsp_saturated_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         tap_ff           <= tap_in;
         dly_valid_ff     <= dly_valid_in;
         sample_ff        <= sample_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_filtered_ff  <= rsp_filtered_in;
         rsp_saturated_ff <= rsp_saturated_in;
      end
   end

   // Read addresses follow the next tap so the registered data matches tap_ff.
   iirtdf2_ram #(
      .WIDTH(COEF_W),
      .DEPTH(MAX_TAPS)
   ) u_num_ram (
      .clock  (clock),
      .wr_en  (num_wr_en),
      .wr_addr(coef_wr_addr),
      .wr_data(req_coef_value),
      .rd_addr(tap_in),
      .rd_data(num_rd)
   );

   iirtdf2_ram #(
      .WIDTH(COEF_W),
      .DEPTH(MAX_TAPS)
   ) u_den_ram (
      .clock  (clock),
      .wr_en  (den_wr_en),
      .wr_addr(coef_wr_addr),
      .wr_data(req_coef_value),
      .rd_addr(tap_in),
      .rd_data(den_rd)
   );

   iirtdf2_ram #(
      .WIDTH(STATE_W),
      .DEPTH(DLY_DEPTH)
   ) u_dly_ram (
      .clock  (clock),
      .wr_en  (dly_wr_en),
      .wr_addr(dly_wr_addr),
      .wr_data(dly_wr_data),
      .rd_addr(tap_in[DLY_AW-1:0]),
      .rd_data(dly_rd)
   );

   iirtdf2_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .coef_b   (num_rd),
      .coef_a   (den_rd),
      .sample   (sample_ff),
      .delay_in (dly_sel),
      .delay_out(dly_wr_data),
      .filtered (mac_filtered),
      .saturated(mac_saturated)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

>>> bench/iir_filter_transposed_df2_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the transposed direct form II IIR filter: drives
// requests and register writes, predicts every output and checks it.
// Depends on iirtdf2_pkg and the iir_filter_transposed_df2 top level.
module iir_filter_transposed_df2_test;

   localparam int MAX_TAPS        = iirtdf2_pkg::MAX_TAPS;
   localparam int COEF_W          = iirtdf2_pkg::COEF_W;
   localparam int SAMPLE_W        = iirtdf2_pkg::SAMPLE_W;
   localparam int STATE_W         = iirtdf2_pkg::STATE_W;
   localparam int COUNT_W         = iirtdf2_pkg::COUNT_W;
   localparam int FRAC_W          = iirtdf2_pkg::FRAC_W;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 66;
   localparam int LIMIT_CYCLES    = 600_000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] filtered;
      logic                saturated;
   } filter_output_type;

   class filter_board_type;
      logic signed [COEF_W-1:0]  numer [MAX_TAPS];
      logic signed [COEF_W-1:0]  denom [MAX_TAPS];
      logic signed [STATE_W-1:0] delay [MAX_TAPS-1];
      bit                        feedback_on;
      logic [COUNT_W-1:0]        taps;
      filter_output_type         pending [$];
      int                        mismatches;
      int                        checked;
      int                        clipped;

      function new();
         foreach (numer[i]) begin
            numer[i] = '0;
            denom[i] = '0;
         end
         foreach (delay[i]) delay[i] = '0;
         feedback_on = 1'b1;
         taps        = 5'd9;
         mismatches  = 0;
         checked     = 0;
         clipped     = 0;
      endfunction

      function void set_register(iirtdf2_pkg::csr_reg_type sel, logic [COUNT_W-1:0] value);
         if (sel == iirtdf2_pkg::CSR_FEEDBACK) feedback_on = value[0];
         else taps = value;
      endfunction

      // Saturate a sum to the Q24.23 state range.
      function longint clamp_state(longint v);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (STATE_W - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // a*y in units of 2^-23, half rounded toward +inf; y split to stay in 64 bits.
      function longint feedback_product(longint a, longint y);
         longint yh;
         longint yl;
         yh = y >>> FRAC_W;
         yl = y - (yh <<< FRAC_W);
         return a * yh + ((a * yl + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W);
      endfunction

      function void filter_sample(logic signed [SAMPLE_W-1:0] smp, logic first_flag);
         longint            x;
         longint            y;
         longint            z;
         longint            r;
         int                n;
         filter_output_type res;
         if (first_flag) foreach (delay[i]) delay[i] = '0;
         n = int'(taps);
         if (n < 1) n = 1;
         if (n > MAX_TAPS) n = MAX_TAPS;
         x = longint'(smp);
         y = longint'(numer[0]) * x;
         if (n > 1) y = y + longint'(delay[0]);
         y = clamp_state(y);
         for (int i = 1; i < n; i++) begin
            z = longint'(numer[i]) * x;
            if (i < n - 1) z = z + longint'(delay[i]);
            if (feedback_on) z = z - feedback_product(longint'(denom[i]), y);
            delay[i-1] = clamp_state(z);
         end
         r = (y + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
         res.saturated = 1'b0;
         if (r > 32767) begin
            r = 32767;
            res.saturated = 1'b1;
         end
         if (r < -32768) begin
            r = -32768;
            res.saturated = 1'b1;
         end
         res.filtered = r[SAMPLE_W-1:0];
         pending.push_back(res);
      endfunction

      function void note_request(iirtdf2_pkg::op_type op, logic [3:0] idx,
                                 logic [COEF_W-1:0] coef, logic [SAMPLE_W-1:0] smp,
                                 logic first_flag);
         case (op)
            iirtdf2_pkg::OP_WRITE_NUM: numer[idx] = coef;
            iirtdf2_pkg::OP_WRITE_DEN: denom[idx] = coef;
            iirtdf2_pkg::OP_FILTER:    filter_sample(smp, first_flag);
            default:                   ;
         endcase
      endfunction

      task flag_mismatch(string what);
         $display("MISMATCH %s", what);
         mismatches++;
      endtask

      task check_result(logic [SAMPLE_W-1:0] filtered, logic saturated);
         filter_output_type want;
         if (pending.size() == 0) begin
            flag_mismatch($sformatf("output %0d with no sample pending", $signed(filtered)));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.saturated) clipped++;
         if (filtered !== want.filtered)
            flag_mismatch($sformatf("output #%0d filtered %0d, want %0d", checked,
                                    $signed(filtered), $signed(want.filtered)));
         if (saturated !== want.saturated)
            flag_mismatch($sformatf("output #%0d saturated %b, want %b", checked,
                                    saturated, want.saturated));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_op;
   logic [3:0]                 req_coef_index;
   logic signed [COEF_W-1:0]   req_coef_value;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_first;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic                       rsp_saturated;
   logic                       csr_wr_en;
   logic [0:0]                 csr_index;
   logic [COUNT_W-1:0]         csr_wdata;

   filter_board_type board = new();
   bit               steady;
   int unsigned      cycle_count = 0;
   int               samples_sent = 0;
   int               writes_sent = 0;

   // Register settings walked by the random part; extremes of tap count included.
   bit                 fb_plan  [PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1, 1, 0};
   logic [COUNT_W-1:0] tap_plan [PHASES] = '{16, 16, 2, 9, 2, 0, 1, 31, 17, 5};

   iir_filter_transposed_df2 dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_sample     (req_sample),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_filtered   (rsp_filtered),
      .rsp_saturated  (rsp_saturated),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // Choose a gap roughly 29 times in a hundred, never during a steady stretch.
   function automatic bit take_gap();
      return !steady && ($urandom_range(0, 99) < 29);
   endfunction

   // Coefficients small enough that most filters stay well inside range.
   function automatic logic [COEF_W-1:0] tame_coef(iirtdf2_pkg::op_type op);
      int unsigned span;
      span = (op == iirtdf2_pkg::OP_WRITE_DEN) ? (32'd1 << 19) : (32'd1 << 21);
      return COEF_W'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one request and hold it until the filter takes it.
   task automatic send_request(iirtdf2_pkg::op_type op, logic [3:0] idx,
                               logic [COEF_W-1:0] coef, logic [SAMPLE_W-1:0] smp,
                               logic first_flag);
      if (take_gap()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_coef_index <= idx;
      req_coef_value <= coef;
      req_sample     <= smp;
      req_first      <= first_flag;
      do @(posedge clock); while (req_stall);
      board.note_request(op, idx, coef, smp, first_flag);
      if (op == iirtdf2_pkg::OP_FILTER) samples_sent++;
      else if (op != iirtdf2_pkg::OP_UNUSED) writes_sent++;
   endtask

   // Drop valid and hold off until every pending output has come back.
   task automatic wait_for_drain(int settle);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(iirtdf2_pkg::csr_reg_type sel, logic [COUNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_register(sel, value);
      @(posedge clock);
   endtask

   // Output side: check what is taken, then decide the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_filtered, rsp_saturated);
      rsp_stall <= take_gap();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d outputs pending", cycle_count,
                  board.pending.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int                  pick;
      logic [3:0]          idx;
      iirtdf2_pkg::op_type wop;
      logic [COEF_W-1:0]   keep;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= iirtdf2_pkg::OP_FILTER;
      req_coef_index <= '0;
      req_coef_value <= '0;
      req_sample     <= '0;
      req_first      <= 1'b0;
      rsp_stall      <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_index      <= iirtdf2_pkg::CSR_FEEDBACK;
      csr_wdata      <= '0;
      steady         <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load every coefficient first so no tap count ever reads an unwritten one.
      for (int i = 0; i < MAX_TAPS; i++) begin
         send_request(iirtdf2_pkg::OP_WRITE_NUM, 4'(i),
                      tame_coef(iirtdf2_pkg::OP_WRITE_NUM), 16'($urandom), 1'($urandom));
         send_request(iirtdf2_pkg::OP_WRITE_DEN, 4'(i),
                      tame_coef(iirtdf2_pkg::OP_WRITE_DEN), 16'($urandom), 1'($urandom));
      end

      // Directed: sample extremes at reset settings, then extreme coefficients
      // to push the internal sums and the output into saturation.
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h7FFF, 1'b1);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h8000, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h0000, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'hFFFF, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h0001, 1'b0);
      // unused op carries no result, even with the first flag set
      send_request(iirtdf2_pkg::OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 16'h7FFF, 1'b1);
      // first flag on a write must not clear the delay line
      keep = board.numer[0];
      send_request(iirtdf2_pkg::OP_WRITE_NUM, 4'd0, 32'h7FFF_FFFF, 16'h0000, 1'b1);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h7FFF, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h8000, 1'b0);
      send_request(iirtdf2_pkg::OP_WRITE_DEN, 4'd1, 32'h8000_0000, 16'h0000, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h7FFF, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h8000, 1'b0);
      send_request(iirtdf2_pkg::OP_WRITE_NUM, 4'd0, 32'h8000_0000, 16'h0000, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h8000, 1'b1);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h7FFF, 1'b0);
      send_request(iirtdf2_pkg::OP_WRITE_DEN, 4'd1, tame_coef(iirtdf2_pkg::OP_WRITE_DEN),
                   16'h0000, 1'b0);
      send_request(iirtdf2_pkg::OP_WRITE_NUM, 4'd0, keep, 16'h0000, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'sd12345, 1'b1);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, -16'sd12345, 1'b0);
      send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, 16'h0000, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         // Settings change only with the filter empty and settled.
         wait_for_drain(8);
         steady <= (p == 3);
         write_register(iirtdf2_pkg::CSR_FEEDBACK, COUNT_W'(fb_plan[p]));
         write_register(iirtdf2_pkg::CSR_TAP_COUNT, tap_plan[p]);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            pick = $urandom_range(0, 99);
            idx  = 4'($urandom);
            wop  = $urandom_range(0, 1) ? iirtdf2_pkg::OP_WRITE_DEN
                                        : iirtdf2_pkg::OP_WRITE_NUM;
            if (pick < 70) begin
               send_request(iirtdf2_pkg::OP_FILTER, idx, COEF_W'($urandom), pick_sample(),
                            $urandom_range(0, 19) == 0);
            end else if (pick < 88) begin
               send_request(wop, idx, tame_coef(wop), 16'($urandom), 1'($urandom));
            end else if (pick < 93) begin
               send_request(iirtdf2_pkg::OP_UNUSED, idx, COEF_W'($urandom), 16'($urandom),
                            1'($urandom));
            end else begin
               // wild coefficient, a few samples through it, then restore a tame one
               send_request(wop, idx, COEF_W'($urandom), 16'($urandom), 1'b0);
               repeat (3) send_request(iirtdf2_pkg::OP_FILTER, 4'd0, '0, pick_sample(), 1'b0);
               send_request(wop, idx, tame_coef(wop), 16'($urandom), 1'b0);
            end
         end
      end

      steady <= 1'b0;
      wait_for_drain(100);
      $display("ran %0d samples and %0d coefficient writes across %0d register settings",
               samples_sent, writes_sent, PHASES + 1);
      $display("checked %0d outputs, %0d of them clipped", board.checked, board.clipped);
      if (board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
